### hw/rtl/plb_pkg.sv
// Shared types and constants for the price-level book builder.
// Used by price_level_book_builder and plb_checker; no dependencies.
`timescale 1ns / 1ps

package plb_pkg;

  // Default configuration
  localparam int PLB_PRICE_LEVELS = 131072;
  localparam int PLB_QTY_WIDTH    = 32;

  // Fixed result field widths
  localparam int PRICE_OUT_W = 17;
  localparam int QTY_OUT_W   = 32;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_EXEC   = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_OTHER  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_we;    // write zero at the clearing address
    logic upd_we;    // write back the updated level
    logic msg_rd;    // read at the incoming word's price
    logic out_load;  // load the result register
  } ctrl_t;

endpackage

### hw/rtl/price_level_book_builder.sv
// An accepted word passes through ST_MODIFY (read-modify-write of its level) and ST_DONE
// (loads the result register); an out-of-range price goes straight to ST_DONE. A rescan of
// a best level takes a RAM read state and a compare state per level examined. One word is
// handled at a time: words are taken only in ST_IDLE, and ST_DONE waits while the output
// stalls; results wait in an output register. Reset (rst, synchronous): a clearing pass
// zeroes both tables with in_stall held high throughout. Depends on plb_pkg and plb_ram.
`timescale 1ns / 1ps

module price_level_book_builder #(
  parameter int PRICE_LEVELS = plb_pkg::PLB_PRICE_LEVELS,
  parameter int QTY_WIDTH    = plb_pkg::PLB_QTY_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         mode,
  input  logic                               side_sell,
  input  logic [31:0]                        price,
  input  logic [31:0]                        shares,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [plb_pkg::PRICE_OUT_W-1:0]    best_bid_price,
  output logic [plb_pkg::PRICE_OUT_W-1:0]    best_ask_price,
  output logic [plb_pkg::QTY_OUT_W-1:0]      level_quantity,
  output logic                               ignored
);

  localparam int LW  = $clog2(PRICE_LEVELS);
  localparam int QW  = QTY_WIDTH;
  localparam int POW = plb_pkg::PRICE_OUT_W;
  localparam int QOW = plb_pkg::QTY_OUT_W;
  localparam logic [LW-1:0] TOP = LW'(PRICE_LEVELS - 1);

  plb_pkg::state_t state, state_next;
  plb_pkg::ctrl_t  ctrl;

  // Latched message
  plb_pkg::mode_t m_mode;
  logic           m_side;
  logic [LW-1:0]  m_lvl;
  logic [31:0]    m_shares;

  logic [LW-1:0] hi_bid, lo_ask;
  logic [LW-1:0] clr_cnt;
  logic [QW-1:0] r_qty;
  logic          r_ign;

  logic [LW-1:0] rd_addr, wr_addr;
  logic [QW-1:0] bid_rd, ask_rd, cur, new_q;
  logic          price_oor, is_add, is_update, scan_start, scan_more, out_free;

  logic [QW+31:0] sh_wide, qmax_wide;
  logic [QW-1:0]  sh_sat, op_b;
  logic [QW:0]    sum;

  logic [LW+POW-1:0] bid_ext, ask_ext;
  logic [QW+QOW-1:0] qty_ext;

  assign price_oor = (price >= 32'(PRICE_LEVELS));
  assign out_free  = !out_valid || !out_stall;
  assign cur       = m_side ? ask_rd : bid_rd;

  // Shared quantity unit: one adder does the saturating add and the floored subtract
  assign sh_wide   = {{QW{1'b0}}, m_shares};
  assign qmax_wide = {32'd0, {QW{1'b1}}};
  assign sh_sat    = (sh_wide > qmax_wide) ? {QW{1'b1}} : sh_wide[QW-1:0];
  assign is_add    = (m_mode == plb_pkg::MODE_ADD);
  assign is_update = (m_mode != plb_pkg::MODE_OTHER);
  assign op_b      = is_add ? sh_sat : ~sh_sat;
  assign sum       = {1'b0, cur} + {1'b0, op_b} + (QW+1)'(!is_add);

  always_comb begin
    if (is_add) begin
      new_q = sum[QW] ? {QW{1'b1}} : sum[QW-1:0];
    end else begin
      new_q = sum[QW] ? sum[QW-1:0] : {QW{1'b0}};
    end
  end

  // Best level emptied: start the rescan one step past it
  always_comb begin
    scan_start = 1'b0;
    case (m_mode) inside
      plb_pkg::MODE_EXEC, plb_pkg::MODE_CANCEL: begin
        if (new_q == '0) begin
          if (m_side) begin
            scan_start = (lo_ask == m_lvl) && (m_lvl != TOP);
          end else begin
            scan_start = (hi_bid == m_lvl) && (m_lvl != '0);
          end
        end
      end
      default: scan_start = 1'b0;
    endcase
  end

  assign scan_more = (cur == '0) && (m_side ? (lo_ask != TOP) : (hi_bid != '0));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      plb_pkg::ST_CLEAR:    if (clr_cnt == TOP) state_next = plb_pkg::ST_IDLE;
      plb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = price_oor ? plb_pkg::ST_DONE : plb_pkg::ST_MODIFY;
        end
      end
      plb_pkg::ST_MODIFY:   state_next = scan_start ? plb_pkg::ST_SCAN_RD : plb_pkg::ST_DONE;
      plb_pkg::ST_SCAN_RD:  state_next = plb_pkg::ST_SCAN_CHK;
      plb_pkg::ST_SCAN_CHK: state_next = scan_more ? plb_pkg::ST_SCAN_RD : plb_pkg::ST_DONE;
      plb_pkg::ST_DONE:     if (out_free) state_next = plb_pkg::ST_IDLE;
      default:              state_next = plb_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    unique case (state)
      plb_pkg::ST_CLEAR: ctrl.clr_we = 1'b1;
      plb_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        ctrl.msg_rd = 1'b1;
      end
      plb_pkg::ST_MODIFY:   ctrl.upd_we = is_update;
      plb_pkg::ST_SCAN_RD,
      plb_pkg::ST_SCAN_CHK: ctrl = '0;
      plb_pkg::ST_DONE:     ctrl.out_load = out_free;
      default:              ctrl = '0;
    endcase
  end

  assign rd_addr = ctrl.msg_rd ? price[LW-1:0] : (m_side ? lo_ask : hi_bid);
  assign wr_addr = ctrl.clr_we ? clr_cnt : m_lvl;

  plb_ram #(.WIDTH(QW), .DEPTH(PRICE_LEVELS)) u_bid_ram (
    .clk     (clk),
    .we      (ctrl.clr_we || (ctrl.upd_we && !m_side)),
    .wr_addr (wr_addr),
    .wr_data (ctrl.clr_we ? {QW{1'b0}} : new_q),
    .rd_addr (rd_addr),
    .rd_data (bid_rd)
  );

  plb_ram #(.WIDTH(QW), .DEPTH(PRICE_LEVELS)) u_ask_ram (
    .clk     (clk),
    .we      (ctrl.clr_we || (ctrl.upd_we && m_side)),
    .wr_addr (wr_addr),
    .wr_data (ctrl.clr_we ? {QW{1'b0}} : new_q),
    .rd_addr (rd_addr),
    .rd_data (ask_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plb_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      hi_bid    <= '0;
      lo_ask    <= TOP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.clr_we) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == plb_pkg::ST_MODIFY) begin
        if (is_add) begin
          if (!m_side && (m_lvl > hi_bid)) hi_bid <= m_lvl;
          if (m_side && (m_lvl < lo_ask))  lo_ask <= m_lvl;
        end else if (scan_start) begin
          if (m_side) lo_ask <= m_lvl + 1'b1;
          else        hi_bid <= m_lvl - 1'b1;
        end
      end
      // Step the best level past another empty entry
      if ((state == plb_pkg::ST_SCAN_CHK) && scan_more) begin
        if (m_side) lo_ask <= lo_ask + 1'b1;
        else        hi_bid <= hi_bid - 1'b1;
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == plb_pkg::ST_IDLE) && in_valid) begin
      m_mode   <= plb_pkg::mode_t'(mode);
      m_side   <= side_sell;
      m_lvl    <= price[LW-1:0];
      m_shares <= shares;
      r_ign    <= price_oor;
      r_qty    <= '0;
    end
    if (state == plb_pkg::ST_MODIFY) begin
      r_qty <= is_update ? new_q : cur;
    end
  end

  assign bid_ext = {{POW{1'b0}}, hi_bid};
  assign ask_ext = {{POW{1'b0}}, lo_ask};
  assign qty_ext = {{QOW{1'b0}}, r_qty};

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      best_bid_price <= bid_ext[POW-1:0];
      best_ask_price <= ask_ext[POW-1:0];
      level_quantity <= qty_ext[QOW-1:0];
      ignored        <= r_ign;
    end
  end

endmodule

### hw/rtl/plb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module plb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/plb_checker.sv
// Port-level checks for price_level_book_builder, attached by bind.
// Depends on plb_pkg.
`timescale 1ns / 1ps

module plb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [plb_pkg::QTY_OUT_W-1:0]   level_quantity,
  input logic                            ignored
);

  // Clearing pass holds the input side off after reset
  a_clear_stall: assert property (@(posedge clk) $past(rst) |-> in_stall)
    else $error("input taken during clearing pass");

  // One word at a time: an accepted word blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while one is in flight");

  // An ignored word reports no quantity
  a_ignored_qty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ignored) |-> (level_quantity == '0))
    else $error("ignored word reports a quantity");

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(level_quantity) && $stable(ignored)))
    else $error("stalled result changed");

endmodule

bind price_level_book_builder plb_checker u_plb_checker (.*);
